>>> design/hmrle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmrle_pkg
// Shared types and constants for the heightmap run-length stream decoder.
// ----------------------------------------------------------------------------
package hmrle_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned HIDX_W       = 3;

    localparam logic [7:0] HEADER_BYTES_B = 8'(HEADER_BYTES);
    localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HEADER_BYTES - 1);

    localparam int unsigned PKT_RLE_BIT = 7;

    localparam logic [HIDX_W-1:0] HIDX_OFFSET  = 3'd0;
    localparam logic [HIDX_W-1:0] HIDX_WIDTH_L = 3'd1;
    localparam logic [HIDX_W-1:0] HIDX_WIDTH_H = 3'd2;
    localparam logic [HIDX_W-1:0] HIDX_DEPTH_L = 3'd3;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 80;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_PKT_HDR = 3'd2,
        PH_RLE_VAL = 3'd3,
        PH_RAW     = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] map_depth;
        logic [15:0] map_width;
        logic        image_done;
        logic [31:0] run_start;
        logic [7:0]  run_length;
        logic [7:0]  run_value;
    } run_t;

endpackage : hmrle_pkg
`default_nettype wire

>>> design/hmrle_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmrle_parser
// Header parse, name skip and packet decode; one byte per accepted beat,
// result produced combinationally from the state registers.
// ----------------------------------------------------------------------------
module hmrle_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              frame_start,
    output logic                   run_valid,
    output hmrle_pkg::run_t        run
);
    import hmrle_pkg::*;

    phase_t                phase_reg, phase_next, phase_eff;
    logic [HIDX_W-1:0]     hidx_reg, hidx_next, hidx_eff;
    logic [7:0]            skip_reg, skip_next;
    logic [15:0]           width_reg, width_next;
    logic [15:0]           depth_reg, depth_next;
    logic [31:0]           pos_reg, pos_next;
    logic [31:0]           rem_reg, rem_next;
    logic [7:0]            pleft_reg, pleft_next;
    logic                  done;
    logic [7:0]            len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            skip_reg  <= '0;
            width_reg <= '0;
            depth_reg <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            pleft_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            skip_reg  <= skip_next;
            width_reg <= width_next;
            depth_reg <= depth_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            pleft_reg <= pleft_next;
        end
    end

    always_comb begin
        phase_eff  = frame_start ? PH_HEADER : phase_reg;
        hidx_eff   = frame_start ? '0 : hidx_reg;
        phase_next = phase_eff;
        hidx_next  = hidx_eff;
        skip_next  = skip_reg;
        width_next = width_reg;
        depth_next = depth_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        pleft_next = pleft_reg;
        done       = 1'b0;
        len        = 8'd1;
        run_valid  = 1'b0;

        unique case (phase_eff)
            PH_HEADER: begin
                unique case (hidx_eff)
                    HIDX_OFFSET:  skip_next = (data_byte >= HEADER_BYTES_B) ?
                                              8'(data_byte - HEADER_BYTES_B) : 8'd0;
                    HIDX_WIDTH_L: width_next[7:0]  = data_byte;
                    HIDX_WIDTH_H: width_next[15:8] = data_byte;
                    HIDX_DEPTH_L: depth_next[7:0]  = data_byte;
                    default:      depth_next[15:8] = data_byte;
                endcase
                hidx_next = hidx_eff + HIDX_W'(1);
                if (hidx_eff == HIDX_LAST) begin
                    hidx_next = '0;
                    pos_next  = '0;
                    rem_next  = 32'(width_next) * 32'(depth_next);
                    if (skip_reg != 8'd0) begin
                        phase_next = PH_SKIP;
                    end else if (width_next == 16'd0 || depth_next == 16'd0) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_PKT_HDR;
                    end
                end
            end
            PH_SKIP: begin
                if (skip_reg != 8'd0) begin
                    skip_next = skip_reg - 8'd1;
                end
                if (skip_reg <= 8'd1) begin
                    phase_next = (rem_reg == 32'd0) ? PH_DONE : PH_PKT_HDR;
                end
            end
            PH_PKT_HDR: begin
                pleft_next = {1'b0, data_byte[6:0]} + 8'd1;
                phase_next = data_byte[PKT_RLE_BIT] ? PH_RLE_VAL : PH_RAW;
            end
            PH_RLE_VAL: begin
                done       = ({24'd0, pleft_reg} >= rem_reg);
                len        = done ? rem_reg[7:0] : pleft_reg;
                pos_next   = pos_reg + 32'(len);
                rem_next   = rem_reg - 32'(len);
                pleft_next = '0;
                phase_next = done ? PH_DONE : PH_PKT_HDR;
                run_valid  = 1'b1;
            end
            PH_RAW: begin
                done     = (rem_reg <= 32'd1);
                pos_next = pos_reg + 32'd1;
                rem_next = rem_reg - 32'd1;
                if (pleft_reg != 8'd0) begin
                    pleft_next = pleft_reg - 8'd1;
                end
                if (done) begin
                    phase_next = PH_DONE;
                end else if (pleft_next == 8'd0) begin
                    phase_next = PH_PKT_HDR;
                end
                run_valid = 1'b1;
            end
            default: begin
            end
        endcase

        run.run_value  = data_byte;
        run.run_length = len;
        run.run_start  = pos_reg;
        run.image_done = done;
        run.map_width  = width_reg;
        run.map_depth  = depth_reg;
    end

endmodule : hmrle_parser
`default_nettype wire

>>> design/heightmap_rle_stream_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_rle_stream_decoder_core
// Decodes a heightmap file byte stream (header, name skip, 8-bit RLE/raw
// packets) into pixel runs clipped at width times depth.
//
//   channel  dir  tdata                              tuser        tlast
//   s_       in   [7:0] data_byte                    frame_start  -
//   m_       out  value, length, start, width, depth -            image_done
//
// One byte per cycle unless s_tready is low; each accepted beat updates the
// parser state and, for RLE value and raw literal bytes, loads the output register.
// Header byte with width*depth uses one 16x16 multiply into the count register.
// Reset: synchronous, active low; parser returns to header byte 0.
// s_tready drops only while a result is held and m_tready is low.
// ----------------------------------------------------------------------------
module heightmap_rle_stream_decoder_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [hmrle_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic                            s_tuser,  // [0] frame_start
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] run_value, [15:8] run_length, [47:16] run_start,
    // [63:48] map_width, [79:64] map_depth
    output logic [hmrle_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast   // image_done
);
    import hmrle_pkg::*;

    logic  accept;
    logic  run_valid;
    run_t  run;
    logic  m_tvalid_reg, m_tvalid_next;
    run_t  out_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hmrle_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata[7:0]),
        .frame_start (s_tuser),
        .run_valid   (run_valid),
        .run         (run)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (accept && run_valid) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && run_valid) begin
            out_reg <= run;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.image_done;
    assign m_tdata  = {out_reg.map_depth, out_reg.map_width, out_reg.run_start,
                       out_reg.run_length, out_reg.run_value};

endmodule : heightmap_rle_stream_decoder_core
`default_nettype wire

>>> sim/heightmap_rle_stream_decoder_core_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_rle_stream_decoder_core_test
// Streams heightmap files into the decoder and checks every run beat against
// a cycle-free model of the parser kept in a small scoreboard class. Covers
// short and long name offsets, empty images, clipped RLE runs, raw packets
// cut off at the image end, trailing bytes, truncated frames and noise, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module heightmap_rle_stream_decoder_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hmrle_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int CALM_BEATS  = 150;
    localparam int PLAN_BEATS  = 1300;

    typedef struct packed {
        logic       fs;
        logic [7:0] b;
    } beat_t;

    class rle_run_tracker;
        phase_t      phase;
        logic [2:0]  hdr_idx;
        logic [7:0]  skip_left;
        logic [15:0] width_q;
        logic [15:0] depth_q;
        logic [31:0] pix_total;
        logic [31:0] pix_pos;
        logic [7:0]  pkt_left;
        logic        pkt_rle;
        run_t        pending_runs[$];
        int unsigned errors;
        int unsigned runs_checked;
        int unsigned bytes_seen;
        int unsigned frames_seen;

        function new();
            clear();
            errors       = 0;
            runs_checked = 0;
            bytes_seen   = 0;
            frames_seen  = 0;
        endfunction

        function void clear();
            phase     = PH_HEADER;
            hdr_idx   = '0;
            skip_left = '0;
            width_q   = '0;
            depth_q   = '0;
            pix_total = '0;
            pix_pos   = '0;
            pkt_left  = '0;
            pkt_rle   = 1'b0;
        endfunction

        function phase_t data_phase();
            return (pix_pos >= pix_total) ? PH_DONE : PH_PKT_HDR;
        endfunction

        function int pending();
            return pending_runs.size();
        endfunction

        function void push_run(logic [7:0] v, logic [7:0] len, logic [31:0] start,
                               logic done);
            run_t r;
            r.run_value  = v;
            r.run_length = len;
            r.run_start  = start;
            r.image_done = done;
            r.map_width  = width_q;
            r.map_depth  = depth_q;
            pending_runs.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic fs);
            logic [31:0] left;
            logic [31:0] len;
            logic [31:0] start;
            logic        done;
            bytes_seen++;
            if (fs) begin
                clear();
                frames_seen++;
            end
            case (phase)
                PH_HEADER: begin
                    case (hdr_idx)
                        HIDX_OFFSET:  skip_left = (b >= HEADER_BYTES_B) ?
                                                  b - HEADER_BYTES_B : 8'd0;
                        HIDX_WIDTH_L: width_q[7:0]  = b;
                        HIDX_WIDTH_H: width_q[15:8] = b;
                        HIDX_DEPTH_L: depth_q[7:0]  = b;
                        default:      depth_q[15:8] = b;
                    endcase
                    hdr_idx = hdr_idx + 3'd1;
                    if (hdr_idx >= HEADER_BYTES) begin
                        pix_total = 32'(width_q) * 32'(depth_q);
                        pix_pos   = '0;
                        phase     = (skip_left != 0) ? PH_SKIP : data_phase();
                    end
                end
                PH_SKIP: begin
                    if (skip_left != 0)
                        skip_left = skip_left - 8'd1;
                    if (skip_left == 0)
                        phase = data_phase();
                end
                PH_PKT_HDR: begin
                    pkt_left = {1'b0, b[6:0]} + 8'd1;
                    pkt_rle  = b[PKT_RLE_BIT];
                    phase    = pkt_rle ? PH_RLE_VAL : PH_RAW;
                end
                PH_RLE_VAL: begin
                    left     = pix_total - pix_pos;
                    len      = (32'(pkt_left) < left) ? 32'(pkt_left) : left;
                    start    = pix_pos;
                    pix_pos  = pix_pos + len;
                    pkt_left = '0;
                    done     = (pix_pos >= pix_total);
                    phase    = done ? PH_DONE : PH_PKT_HDR;
                    push_run(b, len[7:0], start, done);
                end
                PH_RAW: begin
                    start   = pix_pos;
                    pix_pos = pix_pos + 32'd1;
                    if (pkt_left != 0)
                        pkt_left = pkt_left - 8'd1;
                    done = (pix_pos >= pix_total);
                    if (done)
                        phase = PH_DONE;
                    else if (pkt_left == 0)
                        phase = PH_PKT_HDR;
                    push_run(b, 8'd1, start, done);
                end
                default: ;
            endcase
        endfunction

        function void field_ok(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_run(logic [M_TDATA_W-1:0] d, logic last);
            run_t e;
            if (pending_runs.size() == 0) begin
                $error("run beat with nothing pending: tdata=%h tlast=%b", d, last);
                errors++;
                return;
            end
            e = pending_runs.pop_front();
            runs_checked++;
            field_ok("run_value",  32'(e.run_value),  32'(d[7:0]));
            field_ok("run_length", 32'(e.run_length), 32'(d[15:8]));
            field_ok("run_start",  e.run_start,       d[47:16]);
            field_ok("map_width",  32'(e.map_width),  32'(d[63:48]));
            field_ok("map_depth",  32'(e.map_depth),  32'(d[79:64]));
            field_ok("image_done", 32'(e.image_done), 32'(last));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    rle_run_tracker tracker;
    beat_t          byte_plan[$];
    bit             hold_req;
    bit             calm;

    heightmap_rle_stream_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                tracker.check_run(m_tdata, m_tlast);
        end
    end

    function void add_beat(int unsigned b, bit fs);
        beat_t x;
        x.b  = 8'(b);
        x.fs = fs;
        byte_plan.push_back(x);
    endfunction

    function void add_random_frame();
        int unsigned     r;
        int unsigned     offset;
        int unsigned     w;
        int unsigned     d;
        int unsigned     cnt;
        int unsigned     budget;
        int unsigned     cut;
        int              first;
        longint unsigned total;
        longint unsigned covered;
        first = byte_plan.size();
        r = $urandom_range(99);
        if (r < 65)
            offset = $urandom_range(5);
        else if (r < 98)
            offset = $urandom_range(12, 6);
        else
            offset = $urandom_range(255);
        r = $urandom_range(99);
        if (r < 3) begin
            w = 0;
            d = $urandom_range(65535);
        end else if (r < 6) begin
            w = $urandom_range(65535);
            d = 0;
        end else if (r < 16) begin
            w = $urandom_range(65535);
            d = $urandom_range(65535);
        end else begin
            w = $urandom_range(8, 1);
            d = $urandom_range(8, 1);
        end
        add_beat(offset, 1'b1);
        add_beat(w & 8'hFF, 1'b0);
        add_beat(w >> 8, 1'b0);
        add_beat(d & 8'hFF, 1'b0);
        add_beat(d >> 8, 1'b0);
        if (offset > HEADER_BYTES)
            repeat (offset - HEADER_BYTES) add_beat($urandom_range(255), 1'b0);
        total   = longint'(w) * longint'(d);
        covered = 0;
        budget  = (total > 64) ? 6 : 80;
        while (covered < total && budget > 0) begin
            budget--;
            if ($urandom_range(1)) begin
                cnt = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(15);
                add_beat(8'h80 | cnt, 1'b0);
                add_beat($urandom_range(255), 1'b0);
            end else begin
                cnt = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(7);
                add_beat(cnt, 1'b0);
                repeat (cnt + 1) add_beat($urandom_range(255), 1'b0);
            end
            covered += cnt + 1;
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(4, 1)) add_beat($urandom_range(255), 1'b0);
        if ($urandom_range(9) == 0 && byte_plan.size() > first + 2) begin
            cut = $urandom_range(byte_plan.size() - 1, first + 1);
            while (byte_plan.size() > cut)
                void'(byte_plan.pop_back());
        end
        if ($urandom_range(19) == 0)
            repeat ($urandom_range(6, 1))
                add_beat($urandom_range(255), 1'($urandom_range(1)));
    endfunction

    function void build_plan();
        // header before any frame start, offset below header size, raw
        // packet running past a 2x2 image, then a trailing byte
        add_beat(8'h03, 1'b0);
        add_beat(8'h02, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h02, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h81, 1'b0);
        add_beat(8'hAA, 1'b0);
        add_beat(8'h02, 1'b0);
        add_beat(8'h11, 1'b0);
        add_beat(8'h22, 1'b0);
        add_beat(8'h33, 1'b0);
        add_beat(8'h44, 1'b0);
        // name bytes skipped, 1x1 image, 128-pixel RLE clipped to one
        add_beat(8'h07, 1'b1);
        add_beat(8'h01, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h01, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h00, 1'b0);
        // empty image with maximum width
        add_beat(8'h04, 1'b1);
        add_beat(8'hFF, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h80, 1'b0);
        while (byte_plan.size() < PLAN_BEATS)
            add_random_frame();
    endfunction

    task automatic drive_bytes();
        int n;
        int hold_at;
        int pause_at;
        n        = byte_plan.size();
        hold_at  = n / 3;
        pause_at = n / 2;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n - CALM_BEATS);
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at) begin
                s_tvalid = 1'b0;
                while (tracker.pending() != 0)
                    @(negedge aclk);
            end
            if (!calm && $urandom_range(7) == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(16, 1)) @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = byte_plan[i].b;
            s_tuser  = byte_plan[i].fs;
            do
                @(posedge aclk);
            while (!s_tready);
            @(negedge aclk);
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready = 1'b1;
            end else if (!calm && $urandom_range(5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(16, 1)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        tracker  = new();
        hold_req = 1'b0;
        calm     = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        build_plan();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        drive_bytes();
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d bytes over %0d frame starts, %0d runs checked;",
                 tracker.bytes_seen, tracker.frames_seen, tracker.runs_checked);
        $display("random stalls both sides, one long sink hold, one drain pause");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule : heightmap_rle_stream_decoder_core_test
`default_nettype wire

>>> filelist.f
design/hmrle_pkg.sv
design/hmrle_parser.sv
design/heightmap_rle_stream_decoder_core.sv
sim/heightmap_rle_stream_decoder_core_test.sv
